@@ sv/ist_pkg.sv @@
// ----------------------------------------------------------------------------
// ist_pkg
// Shared constants for the integer set table: field widths, operation and
// status codes, slot entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ist_pkg;

  localparam int CAPACITY    = 64;

  localparam int OP_W        = 2;
  localparam int KEY_W       = 25;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;

  // slot entry: {valid, key}
  localparam int ENTRY_W     = KEY_W + 1;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

endpackage

`default_nettype wire

@@ sv/ist_if.sv @@
// ----------------------------------------------------------------------------
// ist_if
// Request and response channels of the integer set table (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface ist_req_if;
  logic                               valid;
  logic                               ready;
  logic [ist_pkg::OP_W-1:0]           operation;
  logic signed [ist_pkg::KEY_W-1:0]   key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface ist_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               was_present;
  logic [ist_pkg::STATUS_W-1:0]       status;
  logic [ist_pkg::COUNT_OUT_W-1:0]    element_count;

  modport source (output valid, output was_present, output status, output element_count,
                  input ready);
  modport sink   (input valid, input was_present, input status, input element_count,
                  output ready);
endinterface

`default_nettype wire

@@ sv/ist_slot_ram.sv @@
// ----------------------------------------------------------------------------
// ist_slot_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ist_slot_ram #(
  parameter int DEPTH = ist_pkg::CAPACITY,
  parameter int WIDTH = ist_pkg::ENTRY_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/integer_set_table.sv @@
// ----------------------------------------------------------------------------
// integer_set_table
// Bounded set of signed keys: insert, delete, query, clear; one response each.
// Each request runs a scan of all slots through the single read port, one slot
// a cycle, before its response; clear then wipes every slot as well.
// One request at a time: the next request is taken only once the last is done,
// even while its response still waits in the output register.
// After reset the slots are wiped before the first request.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_set_table #(
  parameter int CAPACITY = ist_pkg::CAPACITY
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ist_req_if.sink    req_i,
  ist_rsp_if.source  rsp_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = AW + 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                       state_q, state_d;
  logic [SW-1:0]                    cnt_q, cnt_d;
  logic [CW-1:0]                    count_q, count_d;
  logic [ist_pkg::OP_W-1:0]         op_q;
  logic signed [ist_pkg::KEY_W-1:0] key_q;
  logic                             hit_q, hit_d;
  logic [AW-1:0]                    hit_idx_q, hit_idx_d;
  logic                             free_q, free_d;
  logic [AW-1:0]                    free_idx_q, free_idx_d;
  logic                             rd_vld_q, rd_vld_d;
  logic [AW-1:0]                    rd_idx_q;
  logic                             res_present_q, res_present_d;
  logic [ist_pkg::STATUS_W-1:0]     res_status_q, res_status_d;
  logic                             out_valid_q, out_valid_d;
  logic                             out_present_q;
  logic [ist_pkg::STATUS_W-1:0]     out_status_q;
  logic [ist_pkg::COUNT_OUT_W-1:0]  out_count_q;

  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [ist_pkg::ENTRY_W-1:0]      ram_wdata;
  logic [ist_pkg::ENTRY_W-1:0]      ram_rdata;

  logic                             accept;
  logic                             out_load;
  logic                             key_nz;
  logic                             entry_v;
  logic [ist_pkg::KEY_W-1:0]        entry_key;

  ist_slot_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ist_pkg::ENTRY_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign accept    = req_i.valid && req_i.ready;
  assign key_nz    = (key_q != '0);
  assign entry_v   = ram_rdata[ist_pkg::ENTRY_W-1];
  assign entry_key = ram_rdata[ist_pkg::KEY_W-1:0];
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.was_present   = out_present_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.element_count = out_count_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    count_d       = count_q;
    hit_d         = hit_q;
    hit_idx_d     = hit_idx_q;
    free_d        = free_q;
    free_idx_d    = free_idx_q;
    rd_vld_d      = 1'b0;
    res_present_d = res_present_q;
    res_status_d  = res_status_q;
    ram_we        = 1'b0;
    ram_waddr     = cnt_q[AW-1:0];
    ram_wdata     = '0;
    out_valid_d   = out_valid_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT, S_CLR: begin
        // wipe one slot a cycle
        ram_we = 1'b1;
        cnt_d  = cnt_q + SW'(1);
        if (cnt_q == SW'(CAPACITY - 1)) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q < SW'(CAPACITY)) begin
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + SW'(1);
        end
        // read data arrives in the cycle after its address
        if (rd_vld_q) begin
          if (entry_v && key_nz && (entry_key == key_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
          end
          if (!entry_v && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
          if (cnt_q == SW'(CAPACITY)) begin
            state_d = S_UPD;
          end
        end
      end
      S_UPD: begin
        res_present_d = hit_q;
        res_status_d  = ist_pkg::ST_OK;
        state_d       = S_DONE;
        if (op_q == ist_pkg::OP_CLEAR) begin
          count_d = '0;
          cnt_d   = '0;
          state_d = S_CLR;
        end else if (!key_nz) begin
          res_status_d = ist_pkg::ST_ZERO;
        end else if (op_q == ist_pkg::OP_INSERT) begin
          if (!hit_q) begin
            if (free_q) begin
              ram_we    = 1'b1;
              ram_waddr = free_idx_q;
              ram_wdata = {1'b1, key_q};
              count_d   = count_q + CW'(1);
            end else begin
              res_status_d = ist_pkg::ST_FULL;
            end
          end
        end else if (op_q == ist_pkg::OP_DELETE) begin
          if (hit_q) begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx_q;
            ram_wdata = {1'b0, key_q};
            count_d   = count_q - CW'(1);
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      count_q     <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.operation;
      key_q <= req_i.key;
    end
    // response fields hold while the response waits
    if (out_load) begin
      out_present_q <= res_present_q;
      out_status_q  <= res_status_q;
      out_count_q   <= ist_pkg::COUNT_OUT_W'(count_q);
    end
    rd_idx_q      <= cnt_q[AW-1:0];
    hit_idx_q     <= hit_idx_d;
    free_idx_q    <= free_idx_d;
    res_present_q <= res_present_d;
    res_status_q  <= res_status_d;
  end

endmodule

`default_nettype wire
